// ===== hdl/twsm_pkg.sv =====
// Shared types, constants and CRC helpers of the two-wire sensor measurement master.
package twsm_pkg;

    localparam int          TIMEOUT_WIDTH  = 20;
    localparam int          WAIT_WIDTH_DEF = 20;
    localparam logic [19:0] TIMEOUT_RESET  = 20'hAC5FF;
    localparam logic [3:0]  RESET_PULSES   = 4'd15;
    localparam logic [3:0]  START_TICKS    = 4'd5;
    localparam logic [3:0]  BITS_PER_BYTE  = 4'd8;
    localparam logic [7:0]  CRC_POLY       = 8'h31;
    localparam logic [7:0]  CMD_TEMP       = 8'h03;
    localparam logic [7:0]  CMD_HUMI       = 8'h05;
    localparam logic [15:0] BAD_VALUE      = 16'hFFEE;

    // Operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_TEMP  = 2'd1;
    localparam logic [1:0] OP_HUMI  = 2'd2;
    localparam logic [1:0] OP_RESET = 2'd3;

    // Fault codes
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_NOACK  = 2'd1;
    localparam logic [1:0] ERR_TIMEOUT = 2'd2;
    localparam logic [1:0] ERR_CRC    = 2'd3;

    // Byte slots of a read frame
    localparam logic [1:0] BYTE_MSB = 2'd0;
    localparam logic [1:0] BYTE_LSB = 2'd1;
    localparam logic [1:0] BYTE_CHK = 2'd2;
    localparam logic [1:0] BYTE_END = 2'd3;

    // Register index (address bit 2)
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_CRC_EN  = 1'b1;

    typedef enum logic [13:0] {
        PH_IDLE    = 14'h0001,
        PH_RST_HI  = 14'h0002,
        PH_RST_LO  = 14'h0004,
        PH_START   = 14'h0008,
        PH_WR_LO   = 14'h0010,
        PH_WR_HI   = 14'h0020,
        PH_WACK_LO = 14'h0040,
        PH_WACK_HI = 14'h0080,
        PH_WAIT    = 14'h0100,
        PH_RD_LO   = 14'h0200,
        PH_RD_HI   = 14'h0400,
        PH_RACK_LO = 14'h0800,
        PH_RACK_HI = 14'h1000,
        PH_FIN     = 14'h2000
    } t_phase;

    typedef struct packed {
        logic [1:0] operation;
        logic       data_line_in;
    } t_in_word;

    typedef struct packed {
        logic        clock_out;
        logic        data_release;
        logic        busy_res;
        logic        done_res;
        logic [15:0] measured_value;
        logic [7:0]  received_checksum;
        logic [1:0]  error_code;
    } t_out_word;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  pending_mode;
        logic [3:0]  bit_counter;
        logic [1:0]  byte_counter;
        logic [3:0]  pulse_counter;
        logic [7:0]  shift_byte;
        logic [15:0] value_store;
        logic [7:0]  checksum_store;
        logic [7:0]  crc_accum;
        logic [1:0]  fault_code;
    } t_state;

    // CRC-8, polynomial 0x31, MSB first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        for (int k = 0; k < 8; k++) begin
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = v[7-k];
        end
        return r;
    endfunction

endpackage

// ===== hdl/two_wire_sensor_measure_master.sv =====
// Top level of the two-wire sensor measurement master: state registers, result buffer, APB port.
//
// Usage: every input word is one tick, a half phase of the serial clock. It carries an
// operation (tick only, measure temperature, measure humidity, connection reset) and the
// sampled data line level. Every accepted word yields exactly one result word with the
// clock and data line levels to drive for that tick, busy and done flags, the measured
// value, the received checksum and the error code.
// Operations are taken only while the sequencer is idle; the done flag marks the last tick.
// Latency: an input word's result is valid the cycle after acceptance if no earlier result waits.
// Throughput: one word per cycle while o_in_ready is high; the tick update is a single pass
// through the step logic between the state registers, so the state update sets the rate.
// Output side: a two-entry result buffer; input is taken while at most one result waits.
// A receiver stall fills the second slot, and o_in_ready then stays low until a word drains.
// Reset (synchronous, active low): sequencer idle, all stores zero, timeout limit 0xAC5FF,
// checksum check on, result buffer empty.
// APB: timeout_limit at byte address 0, crc_check_enable at byte address 4; write while idle.
module two_wire_sensor_measure_master #(
    parameter int WAIT_COUNTER_WIDTH = twsm_pkg::WAIT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  twsm_pkg::t_in_word   i_in_data,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output twsm_pkg::t_out_word  o_out_data,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    twsm_pkg::t_state                       r_state;
    twsm_pkg::t_state                       n_state;
    logic [WAIT_COUNTER_WIDTH-1:0]          r_wait_cnt;
    logic [WAIT_COUNTER_WIDTH-1:0]          n_wait_cnt;
    logic [twsm_pkg::TIMEOUT_WIDTH-1:0]     r_timeout_limit;
    logic                                   r_crc_check_en;
    twsm_pkg::t_out_word                    n_word;

    // Result buffer: two slots, write and read pointers, fill count
    twsm_pkg::t_out_word                    r_buf0;
    twsm_pkg::t_out_word                    r_buf1;
    logic                                   r_wr_ptr;
    logic                                   r_rd_ptr;
    logic [1:0]                             r_count;

    logic                                   push;
    logic                                   pop;
    logic                                   cfg_wr;

    twsm_step #(
        .WAIT_COUNTER_WIDTH (WAIT_COUNTER_WIDTH)
    ) u_step (
        .i_state         (r_state),
        .i_wait_cnt      (r_wait_cnt),
        .i_word          (i_in_data),
        .i_timeout_limit (r_timeout_limit),
        .i_crc_check_en  (r_crc_check_en),
        .o_state         (n_state),
        .o_wait_cnt      (n_wait_cnt),
        .o_word          (n_word)
    );

    // Take a word while a slot is free
    assign o_in_ready  = (r_count != 2'd2);
    assign push        = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != 2'd0);
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_data  = r_rd_ptr ? r_buf1 : r_buf0;

    // Advance the sequencer only on an accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= twsm_pkg::PH_IDLE;
            r_state.pending_mode   <= '0;
            r_state.bit_counter    <= '0;
            r_state.byte_counter   <= '0;
            r_state.pulse_counter  <= '0;
            r_state.shift_byte     <= '0;
            r_state.value_store    <= '0;
            r_state.checksum_store <= '0;
            r_state.crc_accum      <= '0;
            r_state.fault_code     <= twsm_pkg::ERR_OK;
            r_wait_cnt             <= '0;
        end else if (push) begin
            r_state    <= n_state;
            r_wait_cnt <= n_wait_cnt;
        end
    end

    // Result slots hold payload only
    always_ff @(posedge i_clk) begin
        if (push && !r_wr_ptr) begin
            r_buf0 <= n_word;
        end
        if (push && r_wr_ptr) begin
            r_buf1 <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Configuration registers; bit 2 of the address picks the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_limit <= twsm_pkg::TIMEOUT_RESET;
            r_crc_check_en  <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                twsm_pkg::REG_TIMEOUT: r_timeout_limit <= pwdata[twsm_pkg::TIMEOUT_WIDTH-1:0];
                twsm_pkg::REG_CRC_EN:  r_crc_check_en  <= pwdata[0];
                default:               r_crc_check_en  <= r_crc_check_en;
            endcase
        end
    end

    // Read back aligned addresses, zero elsewhere
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                twsm_pkg::REG_TIMEOUT: prdata = 32'(r_timeout_limit);
                twsm_pkg::REG_CRC_EN:  prdata = 32'(r_crc_check_en);
                default:               prdata = '0;
            endcase
        end
    end

endmodule

// ===== hdl/twsm_step.sv =====
// Per-tick sequencer logic: next bus state and result word from current state and input word.
module twsm_step #(
    parameter int WAIT_COUNTER_WIDTH = twsm_pkg::WAIT_WIDTH_DEF
) (
    input  twsm_pkg::t_state                    i_state,
    input  logic [WAIT_COUNTER_WIDTH-1:0]       i_wait_cnt,
    input  twsm_pkg::t_in_word                  i_word,
    input  logic [twsm_pkg::TIMEOUT_WIDTH-1:0]  i_timeout_limit,
    input  logic                                i_crc_check_en,
    output twsm_pkg::t_state                    o_state,
    output logic [WAIT_COUNTER_WIDTH-1:0]       o_wait_cnt,
    output twsm_pkg::t_out_word                 o_word
);

    localparam int CW = (WAIT_COUNTER_WIDTH > twsm_pkg::TIMEOUT_WIDTH) ?
                        WAIT_COUNTER_WIDTH : twsm_pkg::TIMEOUT_WIDTH;
    localparam logic [WAIT_COUNTER_WIDTH-1:0] WAIT_MAX = '1;

    always_comb begin
        twsm_pkg::t_state             s;
        logic [WAIT_COUNTER_WIDTH-1:0] wc;
        logic clk_lvl;
        logic rel;
        logic busy;
        logic done;

        s       = i_state;
        wc      = i_wait_cnt;
        clk_lvl = 1'b0;
        rel     = 1'b1;
        busy    = 1'b1;
        done    = 1'b0;

        // Start a new sequence on an idle tick; this tick already drives its first step
        if (s.phase == twsm_pkg::PH_IDLE && i_word.operation != twsm_pkg::OP_TICK) begin
            s.pending_mode  = i_word.operation;
            s.pulse_counter = '0;
            s.bit_counter   = '0;
            s.byte_counter  = '0;
            s.fault_code    = twsm_pkg::ERR_OK;
            if (i_word.operation == twsm_pkg::OP_RESET) begin
                s.phase = twsm_pkg::PH_RST_HI;
            end else begin
                s.value_store    = '0;
                s.checksum_store = '0;
                s.crc_accum      = '0;
                s.phase          = twsm_pkg::PH_START;
            end
        end

        unique case (s.phase)
            twsm_pkg::PH_RST_HI: begin
                clk_lvl = 1'b1;
                s.phase = twsm_pkg::PH_RST_LO;
            end
            twsm_pkg::PH_RST_LO: begin
                s.pulse_counter = s.pulse_counter + 4'd1;
                if (s.pulse_counter >= twsm_pkg::RESET_PULSES) begin
                    s.pulse_counter = '0;
                    s.phase         = twsm_pkg::PH_START;
                end else begin
                    s.phase = twsm_pkg::PH_RST_HI;
                end
            end
            twsm_pkg::PH_START: begin
                // Transmission start: data falls with clock high, clock dips, data rises
                clk_lvl = (s.pulse_counter != 4'd2);
                rel     = (s.pulse_counter == 4'd0) || (s.pulse_counter >= 4'd4);
                s.pulse_counter = s.pulse_counter + 4'd1;
                if (s.pulse_counter >= twsm_pkg::START_TICKS) begin
                    s.pulse_counter = '0;
                    if (s.pending_mode == twsm_pkg::OP_RESET) begin
                        s.phase = twsm_pkg::PH_FIN;
                    end else begin
                        s.shift_byte  = (s.pending_mode == twsm_pkg::OP_TEMP) ?
                                        twsm_pkg::CMD_TEMP : twsm_pkg::CMD_HUMI;
                        s.crc_accum   = twsm_pkg::crc8_update(8'h00, s.shift_byte);
                        s.bit_counter = '0;
                        s.phase       = twsm_pkg::PH_WR_LO;
                    end
                end
            end
            twsm_pkg::PH_WR_LO: begin
                rel     = s.shift_byte[7];
                s.phase = twsm_pkg::PH_WR_HI;
            end
            twsm_pkg::PH_WR_HI: begin
                rel           = s.shift_byte[7];
                clk_lvl       = 1'b1;
                s.shift_byte  = {s.shift_byte[6:0], 1'b0};
                s.bit_counter = s.bit_counter + 4'd1;
                s.phase       = (s.bit_counter >= twsm_pkg::BITS_PER_BYTE) ?
                                twsm_pkg::PH_WACK_LO : twsm_pkg::PH_WR_LO;
            end
            twsm_pkg::PH_WACK_LO: begin
                s.phase = twsm_pkg::PH_WACK_HI;
            end
            twsm_pkg::PH_WACK_HI: begin
                clk_lvl = 1'b1;
                if (i_word.data_line_in && s.fault_code == twsm_pkg::ERR_OK) begin
                    s.fault_code = twsm_pkg::ERR_NOACK;
                end
                wc      = '0;
                s.phase = twsm_pkg::PH_WAIT;
            end
            twsm_pkg::PH_WAIT: begin
                if (!i_word.data_line_in) begin
                    s.byte_counter = '0;
                    s.bit_counter  = '0;
                    s.shift_byte   = '0;
                    s.phase        = twsm_pkg::PH_RD_LO;
                end else begin
                    if (wc != WAIT_MAX) begin
                        wc = wc + WAIT_COUNTER_WIDTH'(1);
                    end
                    if (CW'(wc) >= CW'(i_timeout_limit) || wc == WAIT_MAX) begin
                        if (s.fault_code == twsm_pkg::ERR_OK) begin
                            s.fault_code = twsm_pkg::ERR_TIMEOUT;
                        end
                        s.phase = twsm_pkg::PH_FIN;
                    end
                end
            end
            twsm_pkg::PH_RD_LO: begin
                s.phase = twsm_pkg::PH_RD_HI;
            end
            twsm_pkg::PH_RD_HI: begin
                clk_lvl       = 1'b1;
                s.shift_byte  = {s.shift_byte[6:0], i_word.data_line_in};
                s.bit_counter = s.bit_counter + 4'd1;
                if (s.bit_counter >= twsm_pkg::BITS_PER_BYTE) begin
                    case (s.byte_counter)
                        twsm_pkg::BYTE_MSB: begin
                            s.value_store[15:8] = s.shift_byte;
                            s.crc_accum = twsm_pkg::crc8_update(s.crc_accum, s.shift_byte);
                        end
                        twsm_pkg::BYTE_LSB: begin
                            s.value_store[7:0] = s.shift_byte;
                            s.crc_accum = twsm_pkg::crc8_update(s.crc_accum, s.shift_byte);
                        end
                        default: begin
                            s.checksum_store = s.shift_byte;
                        end
                    endcase
                    s.phase = twsm_pkg::PH_RACK_LO;
                end else begin
                    s.phase = twsm_pkg::PH_RD_LO;
                end
            end
            twsm_pkg::PH_RACK_LO: begin
                rel     = (s.byte_counter >= twsm_pkg::BYTE_CHK);
                s.phase = twsm_pkg::PH_RACK_HI;
            end
            twsm_pkg::PH_RACK_HI: begin
                rel            = (s.byte_counter >= twsm_pkg::BYTE_CHK);
                clk_lvl        = 1'b1;
                s.byte_counter = s.byte_counter + 2'd1;
                s.bit_counter  = '0;
                s.shift_byte   = '0;
                if (s.byte_counter == twsm_pkg::BYTE_END) begin
                    if (i_crc_check_en &&
                        twsm_pkg::reverse8(s.crc_accum) != s.checksum_store) begin
                        s.value_store = twsm_pkg::BAD_VALUE;
                        if (s.fault_code == twsm_pkg::ERR_OK) begin
                            s.fault_code = twsm_pkg::ERR_CRC;
                        end
                    end
                    s.phase = twsm_pkg::PH_FIN;
                end else begin
                    s.phase = twsm_pkg::PH_RD_LO;
                end
            end
            twsm_pkg::PH_FIN: begin
                busy    = 1'b0;
                done    = 1'b1;
                s.phase = twsm_pkg::PH_IDLE;
            end
            default: begin
                busy    = 1'b0;
                s.phase = twsm_pkg::PH_IDLE;
            end
        endcase

        o_state                  = s;
        o_wait_cnt               = wc;
        o_word.clock_out         = clk_lvl;
        o_word.data_release      = rel;
        o_word.busy_res          = busy;
        o_word.done_res          = done;
        o_word.measured_value    = s.value_store;
        o_word.received_checksum = s.checksum_store;
        o_word.error_code        = s.fault_code;
    end

endmodule
